FILE: hw/rtl/spt_pkg.sv
// shared types and constants of the stride prefetch table
`default_nettype none

package spt_pkg;

	localparam int ADDR_W    = 32;
	localparam int CONF_W    = 3;
	localparam int CFG_W     = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [CONF_W-1:0] CONF_MAX = 3'd7;
	localparam logic [CONF_W-1:0] CONF_ONE = 3'd1;

	localparam logic [CFG_IDX_W-1:0] REG_CONF_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PREFETCH_DEGREE = 2'd1;

	localparam logic [CFG_W-1:0] THRESHOLD_RESET = 3'd3;
	localparam logic [CFG_W-1:0] DEGREE_RESET    = 3'd4;

	typedef struct packed {
		logic              valid;
		logic              steady;
		logic [CONF_W-1:0] conf;
		logic [ADDR_W-1:0] stride;
		logic [ADDR_W-1:0] last_addr;
	} entry_t;

	typedef struct packed {
		logic rd_en;
		logic upd_en;
		logic clr_en;
	} tbl_ctrl_t;

	typedef struct packed {
		logic              emit;
		logic [ADDR_W-1:0] stride;
	} upd_status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INDEX,
		ST_UPDATE,
		ST_EMIT
	} spt_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spt_index.sv
// table index unit: line number modulo table size by reciprocal multiplication
`default_nettype none

module spt_index import spt_pkg::*; #(
	parameter int TABLE_ENTRIES = 16,
	parameter int LINE_W        = 26
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [LINE_W-1:0]                line,
	output logic                                  done,
	output logic [$clog2(TABLE_ENTRIES)-1:0]      idx
);

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int SHIFT  = LINE_W + IDX_W;
	localparam int MUL_W  = LINE_W + 1;
	localparam int PROD_W = LINE_W + MUL_W;
	localparam int QUOT_W = PROD_W - SHIFT;
	// ceil(2^SHIFT / TABLE_ENTRIES) gives the exact quotient for every line number
	localparam longint unsigned MUL_FULL =
		((64'd1 << SHIFT) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
	localparam logic [MUL_W-1:0]  MUL  = MUL_W'(MUL_FULL);
	localparam logic [LINE_W-1:0] NVAL = LINE_W'(TABLE_ENTRIES);

	logic [LINE_W-1:0] line_s1;
	logic              vld_s1;
	logic [QUOT_W-1:0] quot_s2;
	logic              vld_s2;
	logic [IDX_W-1:0]  back;
	logic [IDX_W-1:0]  idx_q;
	logic              done_q;

	// only the low bits matter since the remainder is below the table size
	assign back = IDX_W'(LINE_W'(quot_s2) * NVAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			line_s1 <= line;
		end
		if (vld_s1) begin
			quot_s2 <= QUOT_W'((PROD_W'(line_s1) * PROD_W'(MUL)) >> SHIFT);
		end
		if (vld_s2) begin
			idx_q <= line_s1[IDX_W-1:0] - back;
		end
	end

	assign done = done_q;
	assign idx  = idx_q;

endmodule

`default_nettype wire

FILE: hw/rtl/spt_table.sv
// entry memory with read-modify-write update of stride and confidence
`default_nettype none

module spt_table import spt_pkg::*; #(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic                             clk,
	input  wire tbl_ctrl_t                        ctrl,
	input  wire logic [$clog2(TABLE_ENTRIES)-1:0] idx,
	input  wire logic [$clog2(TABLE_ENTRIES)-1:0] clr_idx,
	input  wire logic [ADDR_W-1:0]                addr,
	input  wire logic [CFG_W-1:0]                 threshold,
	output upd_status_t                           status
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	entry_t mem [TABLE_ENTRIES];
	entry_t rd_q;
	entry_t upd_entry;
	entry_t wr_data;

	logic [IDX_W-1:0]  wr_idx;
	logic              wr_en;
	logic [ADDR_W-1:0] stride_new;
	logic [CONF_W-1:0] conf_inc;

	always_comb begin
		stride_new = addr - rd_q.last_addr;
		conf_inc   = (rd_q.conf == CONF_MAX) ? rd_q.conf : rd_q.conf + CONF_ONE;
		upd_entry  = rd_q;
		upd_entry.valid     = 1'b1;
		upd_entry.last_addr = addr;
		if (!rd_q.valid) begin
			upd_entry.steady = 1'b0;
		end else if (stride_new == rd_q.stride) begin
			upd_entry.conf   = conf_inc;
			upd_entry.steady = rd_q.steady | (conf_inc >= threshold);
		end else begin
			upd_entry.stride = stride_new;
			upd_entry.conf   = CONF_ONE;
			upd_entry.steady = 1'b0;
		end
		status.emit   = rd_q.valid & upd_entry.steady;
		status.stride = upd_entry.stride;
	end

	assign wr_en   = ctrl.upd_en | ctrl.clr_en;
	assign wr_idx  = ctrl.clr_en ? clr_idx : idx;
	assign wr_data = ctrl.clr_en ? entry_t'('0) : upd_entry;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_q <= mem[idx];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/spt_emit.sv
// prefetch address generator with output register
`default_nettype none

module spt_emit import spt_pkg::*; #(
	parameter int DEG_W = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [ADDR_W-1:0] base,
	input  wire logic [ADDR_W-1:0] stride,
	input  wire logic [DEG_W-1:0]  count,
	output logic                   busy,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [ADDR_W-1:0]      pf_address,
	output logic                   last_of_run
);

	localparam logic [DEG_W-1:0] CNT_ONE = DEG_W'(1);

	logic              busy_q;
	logic              out_valid_q;
	logic              out_last_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [ADDR_W-1:0] acc_q;
	logic [ADDR_W-1:0] stride_q;
	logic [DEG_W-1:0]  remain_q;
	logic [ADDR_W-1:0] acc_next;
	logic              load;

	assign acc_next = acc_q + stride_q;
	assign load     = busy_q & (~out_valid_q | out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (load && remain_q == CNT_ONE) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= base;
			stride_q <= stride;
			remain_q <= count;
		end else if (load) begin
			acc_q      <= acc_next;
			remain_q   <= remain_q - CNT_ONE;
			out_addr_q <= acc_next;
			out_last_q <= (remain_q == CNT_ONE);
		end
	end

	assign busy        = busy_q;
	assign out_valid   = out_valid_q;
	assign pf_address  = out_addr_q;
	assign last_of_run = out_last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/stride_prefetch_table.sv
// stride prefetch table top level: control sequencer and configuration registers
// one request at a time: the line number is reduced to a table index through the line,
// quotient and index registers, then the entry is read and updated read-modify-write
// prefetch addresses leave the emit output register one per cycle while out_ready is high
// a new request waits until the update and any prefetch run end; output stalls delay it
// after reset every table entry is cleared before the first request is taken
`default_nettype none

module stride_prefetch_table import spt_pkg::*; #(
	parameter int TABLE_ENTRIES = 16,
	parameter int LINE_SHIFT    = 6,
	parameter int MAX_DEGREE    = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [ADDR_W-1:0]    access_address,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [ADDR_W-1:0]         pf_address,
	output logic                      last_of_run
);

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int LINE_W = ADDR_W - LINE_SHIFT;
	localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

	spt_state_t state_q;
	spt_state_t state_d;
	tbl_ctrl_t  tbl_ctrl;
	upd_status_t status;

	logic [CFG_W-1:0]  threshold_q;
	logic [CFG_W-1:0]  degree_q;
	logic [DEG_W-1:0]  degree_eff;
	logic [ADDR_W-1:0] addr_q;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic [IDX_W-1:0]  idx;
	logic              idx_done;
	logic              in_accept;
	logic              emit_start;
	logic              emit_busy;

	assign in_accept = in_valid & in_ready;

	always_comb begin
		if (int'(degree_q) > MAX_DEGREE) begin
			degree_eff = DEG_W'(MAX_DEGREE);
		end else begin
			degree_eff = DEG_W'(degree_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_INDEX;
				end
			end
			ST_INDEX: begin
				if (idx_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = emit_start ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (!emit_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready        = 1'b0;
		tbl_ctrl.rd_en  = 1'b0;
		tbl_ctrl.upd_en = 1'b0;
		tbl_ctrl.clr_en = 1'b0;
		emit_start      = 1'b0;
		case (state_q)
			ST_CLEAR: tbl_ctrl.clr_en = 1'b1;
			ST_IDLE:  in_ready = 1'b1;
			ST_INDEX: tbl_ctrl.rd_en = idx_done;
			ST_UPDATE: begin
				tbl_ctrl.upd_en = 1'b1;
				emit_start      = status.emit & (degree_eff != '0);
			end
			ST_EMIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			threshold_q <= THRESHOLD_RESET;
			degree_q    <= DEGREE_RESET;
		end else begin
			state_q <= state_d;
			if (tbl_ctrl.clr_en) begin
				clr_cnt_q <= clr_cnt_q + IDX_ONE;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_CONF_THRESHOLD:  threshold_q <= cfg_wdata;
					REG_PREFETCH_DEGREE: degree_q    <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			addr_q <= access_address;
		end
	end

	spt_index #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.LINE_W       (LINE_W)
	) u_index (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_accept),
		.line  (access_address[ADDR_W-1:LINE_SHIFT]),
		.done  (idx_done),
		.idx   (idx)
	);

	spt_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk      (clk),
		.ctrl     (tbl_ctrl),
		.idx      (idx),
		.clr_idx  (clr_cnt_q),
		.addr     (addr_q),
		.threshold(threshold_q),
		.status   (status)
	);

	spt_emit #(
		.DEG_W(DEG_W)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (emit_start),
		.base       (addr_q),
		.stride     (status.stride),
		.count      (degree_eff),
		.busy       (emit_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pf_address (pf_address),
		.last_of_run(last_of_run)
	);

	a_idle_not_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !emit_busy)
		else $error("request taken while prefetch run in progress");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_done |-> (32'(idx) < TABLE_ENTRIES))
		else $error("table index out of range");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit_start |-> (!emit_busy && state_q == ST_UPDATE))
		else $error("prefetch run started while busy");

	a_update_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_ctrl.upd_en |-> $past(tbl_ctrl.rd_en))
		else $error("entry update without preceding read");

endmodule

`default_nettype wire
